>>> src/sdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_pkg
// shared types, constants and the crc7 step for the sd spi command framer
// ----------------------------------------------------------------------------
package sdf_pkg;

  localparam int unsigned PollLimit = 9;
  localparam int unsigned PollW     = 4;

  localparam logic [7:0] CmdFlag  = 8'h40;
  localparam logic [7:0] IdleByte = 8'hFF;
  localparam logic [6:0] CrcPoly  = 7'h09;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam int unsigned IdxW = 3;
  localparam logic [IdxW-1:0] IdxCmd  = 3'd0;
  localparam logic [IdxW-1:0] IdxArg3 = 3'd1;
  localparam logic [IdxW-1:0] IdxArg2 = 3'd2;
  localparam logic [IdxW-1:0] IdxArg1 = 3'd3;
  localparam logic [IdxW-1:0] IdxArg0 = 3'd4;
  localparam logic [IdxW-1:0] IdxCrc  = 3'd5;
  localparam logic [IdxW-1:0] IdxPoll = 3'd6;

  typedef enum logic {
    JOB_FRAME,
    JOB_RESULT
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic [7:0]  response;
    logic        response_valid;
    logic        timed_out;
  } job_t;

  function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] data);
    logic [6:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[6] ^ data[i];
      c  = {c[5:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> src/sdf_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_cmd_if / sdf_res_if
// valid/ready channels for command words and result words
// ----------------------------------------------------------------------------
interface sdf_cmd_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [5:0]  cmd_index;
  logic [31:0] argument;
  logic [7:0]  rx_byte;

  modport source (output valid, command, cmd_index, argument, rx_byte, input ready);
  modport sink   (input valid, command, cmd_index, argument, rx_byte, output ready);
endinterface

interface sdf_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_valid;
  logic [7:0] response;
  logic       response_valid;
  logic       timed_out;
  logic       last;

  modport source (output valid, tx_byte, tx_valid, response, response_valid, timed_out, last,
                  input ready);
  modport sink   (input valid, tx_byte, tx_valid, response, response_valid, timed_out, last,
                  output ready);
endinterface
`default_nettype wire

>>> src/sdf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_front
// accepts command words, tracks the exchange state and queues jobs
// ----------------------------------------------------------------------------
module sdf_front import sdf_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sdf_cmd_if.sink    cmd_i,
  input  wire logic  q_full_i,
  output logic       push_o,
  output job_t       push_job_o
);

  logic             awaiting_q, awaiting_d;
  logic [PollW-1:0] polls_q, polls_d;
  logic             acc;

  assign cmd_i.ready = !q_full_i;
  assign acc         = cmd_i.valid && cmd_i.ready;

  always_comb begin
    awaiting_d = awaiting_q;
    polls_d    = polls_q;
    push_o     = 1'b0;
    push_job_o = '0;
    push_job_o.cmd_index = cmd_i.cmd_index;
    push_job_o.argument  = cmd_i.argument;
    if (acc) begin
      if (!cmd_i.command) begin
        push_o          = 1'b1;
        push_job_o.kind = JOB_FRAME;
        awaiting_d      = 1'b1;
        polls_d         = PollW'(PollLimit - 1);
      end else if (awaiting_q) begin
        push_o          = 1'b1;
        push_job_o.kind = JOB_RESULT;
        priority if (cmd_i.rx_byte != IdleByte) begin
          push_job_o.response       = cmd_i.rx_byte;
          push_job_o.response_valid = 1'b1;
          awaiting_d                = 1'b0;
          polls_d                   = '0;
        end else if (polls_q == '0) begin
          push_job_o.response       = IdleByte;
          push_job_o.response_valid = 1'b1;
          push_job_o.timed_out      = 1'b1;
          awaiting_d                = 1'b0;
        end else begin
          push_job_o.tx_byte  = IdleByte;
          push_job_o.tx_valid = 1'b1;
          polls_d             = polls_q - PollW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      polls_q    <= '0;
    end else begin
      awaiting_q <= awaiting_d;
      polls_q    <= polls_d;
    end
  end

endmodule
`default_nettype wire

>>> src/sdf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_queue
// short job fifo between the front and back ends
// ----------------------------------------------------------------------------
module sdf_queue import sdf_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire job_t  push_job_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output job_t       head_o
);

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule
`default_nettype wire

>>> src/sdf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_back
// byte sequencer: walks queued jobs out as result words, crc7 on the fly
// ----------------------------------------------------------------------------
module sdf_back import sdf_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  q_valid_i,
  input  wire job_t  q_head_i,
  output logic       pop_o,
  sdf_res_if.source  res_o
);

  logic            busy_q;
  job_t            job_q;
  logic [IdxW-1:0] idx_q;
  logic [6:0]      crc_q, crc_d;

  logic            out_valid_q;
  logic [7:0]      tx_byte_q, response_q;
  logic            tx_valid_q, response_valid_q, timed_out_q, last_q;

  logic            slot_free, emit, fin;
  logic [7:0]      tx_byte_c, response_c;
  logic            tx_valid_c, response_valid_c, timed_out_c, last_c;

  assign slot_free = !out_valid_q || res_o.ready;
  assign emit      = busy_q && slot_free;
  assign fin       = emit && last_c;
  assign pop_o     = q_valid_i && (!busy_q || fin);
  assign crc_d     = crc7_byte(crc_q, tx_byte_c);

  always_comb begin
    tx_byte_c        = '0;
    tx_valid_c       = 1'b0;
    response_c       = '0;
    response_valid_c = 1'b0;
    timed_out_c      = 1'b0;
    last_c           = 1'b1;
    unique case (job_q.kind)
      JOB_FRAME: begin
        tx_valid_c = 1'b1;
        last_c     = (idx_q == IdxPoll);
        unique case (idx_q)
          IdxCmd:  tx_byte_c = {2'b00, job_q.cmd_index} | CmdFlag;
          IdxArg3: tx_byte_c = job_q.argument[31:24];
          IdxArg2: tx_byte_c = job_q.argument[23:16];
          IdxArg1: tx_byte_c = job_q.argument[15:8];
          IdxArg0: tx_byte_c = job_q.argument[7:0];
          IdxCrc:  tx_byte_c = {crc_q, 1'b1};
          default: tx_byte_c = IdleByte;
        endcase
      end
      JOB_RESULT: begin
        tx_byte_c        = job_q.tx_byte;
        tx_valid_c       = job_q.tx_valid;
        response_c       = job_q.response;
        response_valid_c = job_q.response_valid;
        timed_out_c      = job_q.timed_out;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      crc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
        crc_q  <= '0;
      end else if (fin) begin
        busy_q <= 1'b0;
      end else if (emit) begin
        idx_q <= idx_q + IdxW'(1);
        crc_q <= crc_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= q_head_i;
    end
    if (emit) begin
      tx_byte_q        <= tx_byte_c;
      tx_valid_q       <= tx_valid_c;
      response_q       <= response_c;
      response_valid_q <= response_valid_c;
      timed_out_q      <= timed_out_c;
      last_q           <= last_c;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.tx_byte        = tx_byte_q;
  assign res_o.tx_valid       = tx_valid_q;
  assign res_o.response       = response_q;
  assign res_o.response_valid = response_valid_q;
  assign res_o.timed_out      = timed_out_q;
  assign res_o.last           = last_q;

endmodule
`default_nettype wire

>>> src/sd_spi_command_framer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sd_spi_command_framer
// sd card spi-mode command framing with crc7 and r1 response polling
// ----------------------------------------------------------------------------
// A start word (command 0) yields seven result words: the command byte, four
// argument bytes msb first, the crc7 byte and a first 0xff poll byte, the last
// one flagged. A received-byte word (command 1) yields one result word while an
// exchange is open: the r1 response, another 0xff poll, or a 0xff timeout
// after nine polls in all; it is dropped when no exchange is open. The front
// end decides each word in the cycle it is accepted and queues a job (two
// deep); the back end sequencer emits one result word per cycle while the
// result side is ready, and that sequencer sets the sustained rate. Words are
// taken while results wait, until the job queue is full.
module sd_spi_command_framer import sdf_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sdf_cmd_if.sink    cmd_i,
  sdf_res_if.source  res_o
);

  logic push, q_full, pop, q_valid;
  job_t push_job, q_head;

  sdf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_job_o (push_job)
  );

  sdf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  sdf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .pop_o     (pop),
    .res_o     (res_o)
  );

endmodule
`default_nettype wire

>>> tb/sv/sd_spi_command_framer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_spi_command_framer_tb
// Drives start words and received-byte words into the framer, predicts every
// result word (frame bytes, crc7, polls, r1 responses and timeouts) and checks
// them in order, with random idle bursts on both the command and result side.
// ----------------------------------------------------------------------------
module sd_spi_command_framer_tb;
  import sdf_pkg::*;

  localparam logic CmdStart  = 1'b0;
  localparam logic CmdRxByte = 1'b1;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandItems  = 150;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [7:0] response;
    logic       response_valid;
    logic       timed_out;
    logic       last;
  } frame_result_t;

  typedef struct packed {
    logic        command;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic [7:0]  rx_byte;
  } cmd_word_t;

  class framer_scoreboard;
    frame_result_t pending_q[$];
    bit            awaiting;
    logic [3:0]    polls_left;
    int unsigned   errors;

    function new();
      awaiting   = 1'b0;
      polls_left = '0;
      errors     = 0;
    endfunction

    function logic [6:0] frame_crc7(logic [39:0] msg);
      logic [6:0] r;
      r = '0;
      for (int i = 39; i >= 0; i--) begin
        if (r[6] ^ msg[i]) begin
          r = {r[5:0], 1'b0} ^ CrcPoly;
        end else begin
          r = {r[5:0], 1'b0};
        end
      end
      return r;
    endfunction

    function void add(logic [7:0] tx, logic txv, logic [7:0] resp, logic respv,
                      logic to, logic lst);
      frame_result_t e;
      e = '{tx_byte: tx, tx_valid: txv, response: resp, response_valid: respv,
            timed_out: to, last: lst};
      pending_q.push_back(e);
    endfunction

    function void note_word(cmd_word_t w);
      logic [39:0] msg;
      logic [6:0]  crc;
      if (w.command == CmdStart) begin
        msg = {CmdFlag | {2'b00, w.cmd_index}, w.argument};
        crc = frame_crc7(msg);
        for (int k = 4; k >= 0; k--) begin
          add(msg[k*8 +: 8], 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
        end
        add({crc, 1'b1}, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
        add(IdleByte, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1);
        awaiting   = 1'b1;
        polls_left = 4'(PollLimit - 1);
      end else if (awaiting) begin
        if (w.rx_byte != IdleByte) begin
          add(8'h00, 1'b0, w.rx_byte, 1'b1, 1'b0, 1'b1);
          awaiting   = 1'b0;
          polls_left = '0;
        end else if (polls_left == 0) begin
          add(8'h00, 1'b0, IdleByte, 1'b1, 1'b1, 1'b1);
          awaiting = 1'b0;
        end else begin
          polls_left = polls_left - 4'd1;
          add(IdleByte, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1);
        end
      end
    endfunction

    function void check_field(string name, logic [7:0] exp, logic [7:0] act);
      if (act !== exp) begin
        $display("%0t mismatch %s expected %0h actual %0h", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t e;
      if (pending_q.size() == 0) begin
        $display("%0t unexpected word expected none actual %0h", $time, got);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      check_field("tx_byte", e.tx_byte, got.tx_byte);
      check_field("tx_valid", 8'(e.tx_valid), 8'(got.tx_valid));
      check_field("response", e.response, got.response);
      check_field("response_valid", 8'(e.response_valid), 8'(got.response_valid));
      check_field("timed_out", 8'(e.timed_out), 8'(got.timed_out));
      check_field("last", 8'(e.last), 8'(got.last));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  sdf_cmd_if cmd_if ();
  sdf_res_if res_if ();

  framer_scoreboard sb;
  cmd_word_t        stim_q[$];
  bit               calm;
  bit               gaps_on;
  int unsigned      cycle_cnt;

  sd_spi_command_framer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // input side first so a same-edge result always finds its expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cmd_if.valid && cmd_if.ready) begin
        sb.note_word('{command: cmd_if.command, cmd_index: cmd_if.cmd_index,
                       argument: cmd_if.argument, rx_byte: cmd_if.rx_byte});
      end
      if (res_if.valid && res_if.ready) begin
        sb.check_result('{tx_byte: res_if.tx_byte, tx_valid: res_if.tx_valid,
                          response: res_if.response,
                          response_valid: res_if.response_valid,
                          timed_out: res_if.timed_out, last: res_if.last});
      end
    end
  end

  function automatic void push_start(logic [5:0] idx, logic [31:0] arg);
    stim_q.push_back('{command: CmdStart, cmd_index: idx, argument: arg,
                       rx_byte: 8'($urandom)});
  endfunction

  function automatic void push_rx(logic [7:0] b);
    stim_q.push_back('{command: CmdRxByte, cmd_index: 6'($urandom),
                       argument: $urandom, rx_byte: b});
  endfunction

  task automatic build_stimulus();
    int unsigned cnt;
    int unsigned polls;
    push_rx(8'h00);
    push_start(6'd0, 32'h0000_0000);
    push_rx(8'h01);
    push_start(6'd63, 32'hFFFF_FFFF);
    repeat (PollLimit) push_rx(IdleByte);
    push_start(6'd8, 32'h0000_01AA);
    push_rx(IdleByte);
    push_rx(8'h00);
    push_start(6'd17, 32'h1234_5678);
    push_start(6'd55, 32'h8000_0001);
    push_rx(8'hFE);
    push_rx(IdleByte);
    cnt = 0;
    while (cnt < RandItems) begin
      if ($urandom_range(0, 9) == 0) begin
        push_rx(8'($urandom));
      end else begin
        push_start(6'($urandom), $urandom);
        cnt++;
        polls = $urandom_range(0, 10);
        repeat (polls) push_rx(IdleByte);
        cnt += polls;
        if ($urandom_range(0, 3) != 0) begin
          push_rx(8'($urandom_range(0, 254)));
          cnt++;
        end
      end
    end
  endtask

  task automatic drive_words();
    for (int i = 0; i < stim_q.size(); i++) begin
      calm = (i + 25 >= stim_q.size());
      if (i % 16 == 0) begin
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      cmd_if.valid     <= 1'b1;
      cmd_if.command   <= stim_q[i].command;
      cmd_if.cmd_index <= stim_q[i].cmd_index;
      cmd_if.argument  <= stim_q[i].argument;
      cmd_if.rx_byte   <= stim_q[i].rx_byte;
      do @(posedge clk_i); while (!cmd_if.ready);
      if (!calm && gaps_on && $urandom_range(0, 2) == 0) begin
        cmd_if.valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
    end
    cmd_if.valid <= 1'b0;
  endtask

  // result side back-pressure
  initial begin
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      if (!calm && $urandom_range(0, 3) != 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
    end
  end

  initial begin
    sb               = new();
    calm             = 1'b0;
    gaps_on          = 1'b0;
    cycle_cnt        = 0;
    rst_ni           <= 1'b0;
    cmd_if.valid     <= 1'b0;
    cmd_if.command   <= CmdStart;
    cmd_if.cmd_index <= '0;
    cmd_if.argument  <= '0;
    cmd_if.rx_byte   <= '0;
    build_stimulus();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    drive_words();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
src/sdf_pkg.sv
src/sdf_if.sv
src/sdf_front.sv
src/sdf_queue.sv
src/sdf_back.sv
src/sd_spi_command_framer.sv
tb/sv/sd_spi_command_framer_tb.sv
